[rtl/bba_pkg.sv]
// ---------------------------------------------------------------------------
// bba_pkg
// Shared constants and sequencer states for the buddy block allocator.
// ---------------------------------------------------------------------------
package bba_pkg;
  localparam int MAX_ORDER_DEF   = 10;
  localparam int ALLOC_SLOTS_DEF = 64;
  localparam int ID_W            = 31;
  localparam int SIZE_W          = 16;
  localparam int POOL_W          = 11;
  localparam int POOL_RESET      = 1024;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic ST_OK   = 1'b0;
  localparam logic ST_FAIL = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,     // walk the table: free slot or matching id
    S_DECIDE,
    S_SPLIT_RD, // pop top of a larger order
    S_SPLIT_WT,
    S_SPLIT_PU, // push upper halves, then lower half
    S_POP_RD,
    S_POP_WT,
    S_MRG_RD,   // search buddy in order stack
    S_MRG_WT,
    S_MRG_CMP,
    S_SHIFT_RD, // compact stack after removal
    S_SHIFT_WT,
    S_PUSH,
    S_RESP
  } state_t;
endpackage

[rtl/buddy_block_allocator.sv]
// ---------------------------------------------------------------------------
// buddy_block_allocator
// Buddy allocator with per-order free stacks in one RAM and an id table.
// ---------------------------------------------------------------------------
// Usage: s_axis carries one request beat: tdata = {alloc_id, size}
// (size in the low bits), tuser = op (0 allocate, 1 free). m_axis carries
// one response beat per request: tdata = new_id, tuser = status (0 success).
// The block works on one request at a time; s_axis_tready is low from the
// accepted beat until the response is taken. Every request first walks the
// ALLOC_SLOTS table one slot per cycle through a registered read. An
// allocate then pops or splits through the free-stack RAM, which has one
// write port and one registered read port. A free searches the stack of
// each merged order for the buddy entry by entry and compacts it by moving
// the later entries down one place.
// Reset (rst, synchronous) and a cfg_we write both restore the initial
// pool: one free block of the top order at address 0, empty table, id 1.
// A stalled m_axis holds the response; no new request is taken meanwhile.
// ---------------------------------------------------------------------------
module buddy_block_allocator #(
  parameter int MAX_ORDER   = bba_pkg::MAX_ORDER_DEF,
  parameter int ALLOC_SLOTS = bba_pkg::ALLOC_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [10:0] cfg_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // size[15:0], alloc_id[46:16], zero
  input  logic        s_axis_tuser,  // op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // new_id[30:0], zero
  output logic        m_axis_tuser   // status
);
  import bba_pkg::*;

  localparam int NORD  = MAX_ORDER + 1;
  localparam int OW    = $clog2(NORD + 1);
  localparam int AW    = (MAX_ORDER > 0) ? MAX_ORDER : 1;
  localparam int SAW   = MAX_ORDER + 1;
  localparam int DEPTH = 1 << SAW;
  localparam int CW    = MAX_ORDER + 1;
  localparam int SW    = (ALLOC_SLOTS > 1) ? $clog2(ALLOC_SLOTS) : 1;
  localparam int SCW   = $clog2(ALLOC_SLOTS + 2);

  // free stack RAM and per-order depths
  logic [AW-1:0]  fmem [DEPTH];
  logic [CW-1:0]  fcnt [NORD];
  logic [OW-1:0]  top_order;
  // allocation table
  logic [ALLOC_SLOTS-1:0] slot_valid;
  logic [ID_W-1:0] slot_id    [ALLOC_SLOTS];
  logic [AW-1:0]   slot_addr  [ALLOC_SLOTS];
  logic [OW-1:0]   slot_order [ALLOC_SLOTS];
  logic [ID_W-1:0] slot_id_q;
  logic [AW-1:0]   slot_addr_q;
  logic [OW-1:0]   slot_order_q;
  logic [ID_W-1:0] id_counter;

  state_t state, state_next;
  logic          op_r;
  logic [OW-1:0] req_order;
  logic [ID_W-1:0] req_id;
  logic [SCW-1:0] scan;
  logic [SW-1:0] prev_slot;
  logic          found;
  logic [SW-1:0] hit_slot;
  logic [OW-1:0] ord;     // working order
  logic [OW-1:0] kord;    // split push order
  logic [AW-1:0] addr;
  logic [CW-1:0] idx;
  logic [AW-1:0] rdata;
  logic          ram_we;
  logic [SAW-1:0] ram_waddr, ram_raddr;
  logic [AW-1:0] ram_wdata;
  logic          resp_status;
  logic [ID_W-1:0] resp_id;
  logic          too_big;
  logic [OW-1:0] size_order;
  logic [OW-1:0] init_top;

  // base of an order's stack in the RAM
  function automatic logic [SAW-1:0] obase(input logic [OW-1:0] o);
    logic [SAW:0] full;
    full = (SAW+1)'(DEPTH) - ((SAW+1)'(1) << (SAW - int'(o)));
    return full[SAW-1:0];
  endfunction

  // pool rounding of a config write, saturated to MAX_ORDER
  function automatic logic [OW-1:0] pool_order(input logic [POOL_W-1:0] v);
    logic [OW-1:0] k;
    k = '0;
    for (int i = 0; i < POOL_W; i++)
      if ((POOL_W+1)'(v) > ((POOL_W+1)'(1) << i)) k = OW'(i + 1);
    if (k > OW'(MAX_ORDER)) k = OW'(MAX_ORDER);
    return k;
  endfunction

  // top order after reset or a pool write
  assign init_top = rst ? pool_order(POOL_W'(POOL_RESET)) : pool_order(cfg_wdata);

  // round request size up to an order; flag sizes beyond MAX_ORDER
  always_comb begin
    size_order = '0;
    too_big    = 1'b0;
    for (int i = 0; i < SIZE_W; i++)
      if (s_axis_tdata[SIZE_W-1:0] > (SIZE_W)'(1 << i)) begin
        if (i + 1 > MAX_ORDER) too_big = 1'b1;
        else size_order = OW'(i + 1);
      end
  end

  assign s_axis_tready = (state == S_IDLE);
  wire in_beat = s_axis_tvalid && s_axis_tready;
  wire cmp_hit = (rdata == (addr ^ AW'(1 << ord)));
  // table entry whose registered read is on slot_*_q
  assign prev_slot = SW'(scan - SCW'(1));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:     if (in_beat) state_next = S_SCAN;
      S_SCAN:     if (found || scan == SCW'(ALLOC_SLOTS + 1)) state_next = S_DECIDE;
      S_DECIDE: begin
        if (op_r == OP_FREE) begin
          if (!found) state_next = S_RESP;
          else if (ord < top_order) state_next = S_MRG_RD;
          else state_next = S_PUSH;
        end else if (!found || req_order > top_order || req_order == '1)
          state_next = S_RESP;
        else if (fcnt[req_order] != '0) state_next = S_POP_RD;
        else if (ord > top_order) state_next = S_RESP;
        else if (fcnt[ord] != '0) state_next = S_SPLIT_RD;
      end
      S_SPLIT_RD: state_next = S_SPLIT_WT;
      S_SPLIT_WT: state_next = S_SPLIT_PU;
      S_SPLIT_PU: if (kord == req_order) state_next = S_POP_RD;
      S_POP_RD:   state_next = S_POP_WT;
      S_POP_WT:   state_next = S_RESP;
      S_MRG_RD:   state_next = (idx == fcnt[ord]) ? S_PUSH : S_MRG_WT;
      S_MRG_WT:   state_next = S_MRG_CMP;
      S_MRG_CMP:  state_next = cmp_hit ? S_SHIFT_RD : S_MRG_RD;
      S_SHIFT_RD: begin
        if (idx + CW'(1) >= fcnt[ord]) begin
          state_next = (ord + OW'(1) < top_order) ? S_MRG_RD : S_PUSH;
        end else state_next = S_SHIFT_WT;
      end
      S_SHIFT_WT: state_next = S_SHIFT_RD;
      S_PUSH:     state_next = S_RESP;
      S_RESP:     if (m_axis_tready) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // RAM port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = obase(ord) + SAW'(idx);
    ram_wdata = addr;
    ram_raddr = obase(ord) + SAW'(idx);
    unique case (state)
      S_SPLIT_RD: ram_raddr = obase(ord) + SAW'(fcnt[ord] - CW'(1));
      S_SPLIT_PU: begin
        ram_we = 1'b1;
        if (kord == req_order) begin
          ram_waddr = obase(kord) + SAW'(fcnt[kord]);
          ram_wdata = addr;
        end else begin
          ram_waddr = obase(kord - OW'(1)) + SAW'(fcnt[kord - OW'(1)]);
          ram_wdata = addr + AW'(1 << (kord - OW'(1)));
        end
      end
      S_POP_RD:   ram_raddr = obase(req_order) + SAW'(fcnt[req_order] - CW'(1));
      S_SHIFT_RD: ram_raddr = obase(ord) + SAW'(idx + CW'(1));
      S_SHIFT_WT: begin
        ram_we    = 1'b1;
        ram_wdata = rdata;
      end
      S_PUSH: begin
        ram_we    = (fcnt[ord] < CW'(1 << (MAX_ORDER - ord)));
        ram_waddr = obase(ord) + SAW'(fcnt[ord]);
      end
      default: ;
    endcase
    // seed the top order's stack with address 0
    if (rst || cfg_we) begin
      ram_we    = 1'b1;
      ram_waddr = obase(init_top);
      ram_wdata = '0;
    end
  end

  // free stack RAM, registered read
  always_ff @(posedge clk) begin
    if (ram_we) fmem[ram_waddr] <= ram_wdata;
    rdata <= fmem[ram_raddr];
  end

  // allocation table, registered read at the scan position
  always_ff @(posedge clk) begin
    slot_id_q    <= slot_id[scan[SW-1:0]];
    slot_addr_q  <= slot_addr[scan[SW-1:0]];
    slot_order_q <= slot_order[scan[SW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // datapath
  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      top_order  <= init_top;
      for (int o = 0; o < NORD; o++) fcnt[o] <= (OW'(o) == init_top) ? CW'(1) : '0;
      slot_valid <= '0;
      id_counter <= ID_W'(1);
    end else begin
      unique case (state)
        S_IDLE: begin
          op_r   <= s_axis_tuser;
          req_id <= s_axis_tdata[SIZE_W +: ID_W];
          req_order <= (s_axis_tdata[SIZE_W-1:0] == '0 || too_big) ? '1 : size_order;
          scan   <= '0;
          found  <= 1'b0;
        end
        S_SCAN: if (!found && scan != SCW'(ALLOC_SLOTS + 1)) begin
          if (scan != '0 && (op_r == OP_FREE ? (slot_valid[prev_slot] &&
                                                 slot_id_q == req_id)
                                             : !slot_valid[prev_slot])) begin
            found    <= 1'b1;
            hit_slot <= prev_slot;
            addr     <= slot_addr_q;
            ord      <= (slot_order_q > top_order) ? top_order : slot_order_q;
          end
          scan <= scan + SCW'(1);
        end else begin
          if (op_r == OP_ALLOC) ord <= req_order + OW'(1);
          idx <= '0;
        end
        S_DECIDE: begin
          resp_status <= ST_FAIL;
          resp_id     <= '0;
          if (op_r == OP_ALLOC && found && req_order <= top_order &&
              req_order != '1 && fcnt[req_order] == '0 && ord <= top_order &&
              fcnt[ord] == '0)
            ord <= ord + OW'(1);
          if (op_r == OP_FREE && found) begin
            resp_status          <= ST_OK;
            slot_valid[hit_slot] <= 1'b0;
          end
        end
        S_SPLIT_RD: fcnt[ord] <= fcnt[ord] - CW'(1);
        // take the popped block before the first push
        S_SPLIT_WT: begin
          kord <= ord;
          addr <= rdata;
        end
        S_SPLIT_PU: begin
          if (kord == req_order) begin
            fcnt[kord] <= fcnt[kord] + CW'(1);
          end else begin
            fcnt[kord - OW'(1)] <= fcnt[kord - OW'(1)] + CW'(1);
            kord <= kord - OW'(1);
          end
        end
        S_POP_RD: fcnt[req_order] <= fcnt[req_order] - CW'(1);
        S_POP_WT: begin
          slot_valid[hit_slot] <= 1'b1;
          slot_id[hit_slot]    <= id_counter;
          slot_addr[hit_slot]  <= rdata;
          slot_order[hit_slot] <= req_order;
          resp_status <= ST_OK;
          resp_id     <= id_counter;
          id_counter  <= (id_counter + ID_W'(1) == '0) ? ID_W'(1)
                                                       : id_counter + ID_W'(1);
        end
        S_MRG_RD: ;
        S_MRG_CMP: if (!cmp_hit) idx <= idx + CW'(1);
        S_SHIFT_RD: begin
          if (idx + CW'(1) >= fcnt[ord]) begin
            fcnt[ord] <= fcnt[ord] - CW'(1);
            if ((addr ^ AW'(1 << ord)) < addr) addr <= addr ^ AW'(1 << ord);
            ord <= ord + OW'(1);
            idx <= '0;
          end
        end
        S_SHIFT_WT: idx <= idx + CW'(1);
        S_PUSH: if (fcnt[ord] < CW'(1 << (MAX_ORDER - ord))) fcnt[ord] <= fcnt[ord] + CW'(1);
        default: ;
      endcase
    end
  end

  assign m_axis_tvalid = (state == S_RESP);
  assign m_axis_tuser  = resp_status;
  assign m_axis_tdata  = {1'b0, resp_id};

  // checks
  a_busy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready) else $error("ready while response pending");
  a_hold: assert property (@(posedge clk) disable iff (rst || cfg_we)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("response dropped");
  a_okid: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata != '0 |-> m_axis_tuser == ST_OK)
    else $error("id on failure");
endmodule

[sim/tb_buddy_block_allocator.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_buddy_block_allocator
// Self-checking bench: a behavioral buddy allocator predicts each response,
// a scoreboard compares response beats in order, across several pool sizes
// and idle/stall phases.
// ---------------------------------------------------------------------------
module tb_buddy_block_allocator;
  import bba_pkg::*;

  localparam int NORD  = MAX_ORDER_DEF + 1;
  localparam int NSLOT = ALLOC_SLOTS_DEF;
  localparam int WDOG_LIMIT = 20000;

  typedef struct packed {
    logic          status;
    logic [ID_W-1:0] id;
  } resp_t;

  // Behavioral allocator plus queue of expected responses
  class alloc_scoreboard;
    int unsigned top;
    int unsigned stk[NORD][$];
    bit          sv[NSLOT];
    bit [30:0]   sid[NSLOT];
    int unsigned saddr[NSLOT];
    int unsigned sord[NSLOT];
    bit [30:0]   next_id;
    resp_t       pending[$];
    int          errors;
    int          live;

    // stack helpers: push on top, take from top
    function void push_free(int unsigned o, int unsigned a);
      stk[o].insert(stk[o].size(), a);
    endfunction

    function int unsigned pop_free(int unsigned o);
      int unsigned a;
      a = stk[o][$];
      stk[o].delete(stk[o].size() - 1);
      return a;
    endfunction

    function void init_pool(int unsigned pool);
      int unsigned t;
      t = 0;
      while ((1 << t) < pool && t < 31) t++;
      if (t > MAX_ORDER_DEF) t = MAX_ORDER_DEF;
      top = t;
      foreach (stk[o]) stk[o].delete();
      foreach (sv[s]) sv[s] = 0;
      push_free(top, 0);
      next_id = 1;
      live = 0;
    endfunction

    function resp_t do_alloc(int unsigned size);
      resp_t r;
      int unsigned o, k, a, slot;
      r = '{status: ST_FAIL, id: '0};
      if (size == 0) return r;
      o = 0;
      while ((1 << o) < size) o++;
      if (o > top) return r;
      slot = NSLOT;
      for (int s = NSLOT - 1; s >= 0; s--) if (!sv[s]) slot = s;
      if (slot == NSLOT) return r;
      // split the first larger free block down to the needed order
      if (stk[o].size() == 0) begin
        for (int unsigned b = o + 1; b <= top; b++) begin
          if (stk[b].size() != 0) begin
            a = pop_free(b);
            for (k = b; k > o; k--) push_free(k - 1, a + (1 << (k - 1)));
            push_free(o, a);
            break;
          end
        end
      end
      if (stk[o].size() == 0) return r;
      a = pop_free(o);
      sv[slot] = 1; sid[slot] = next_id; saddr[slot] = a; sord[slot] = o;
      r = '{status: ST_OK, id: next_id};
      next_id++;
      if (next_id == 0) next_id = 1;
      live++;
      return r;
    endfunction

    function resp_t do_free(bit [30:0] id);
      int unsigned slot, o, a, bud;
      int idx;
      slot = NSLOT;
      for (int s = NSLOT - 1; s >= 0; s--) if (sv[s] && sid[s] == id) slot = s;
      if (slot == NSLOT) return '{status: ST_FAIL, id: '0};
      o = sord[slot]; a = saddr[slot];
      if (o > top) o = top;
      // merge with free buddies while present
      while (o < top) begin
        bud = a ^ (1 << o);
        idx = -1;
        for (int i = 0; i < stk[o].size(); i++)
          if (idx < 0 && stk[o][i] == bud) idx = i;
        if (idx < 0) break;
        stk[o].delete(idx);
        if (bud < a) a = bud;
        o++;
      end
      push_free(o, a);
      sv[slot] = 0;
      live--;
      return '{status: ST_OK, id: '0};
    endfunction

    function void note_request(logic op, int unsigned size, bit [30:0] id);
      pending.insert(pending.size(), op == OP_ALLOC ? do_alloc(size) : do_free(id));
    endfunction

    function void check_response(logic status, bit [30:0] id);
      resp_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected response status=%0d id=%0d", $time, status, id);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (e.status !== status) begin
        $display("%0t: status mismatch expected %0d actual %0d", $time, e.status, status);
        errors++;
      end
      if (e.id !== id) begin
        $display("%0t: new_id mismatch expected %0d actual %0d", $time, e.id, id);
        errors++;
      end
    endfunction

    // pick a live id, or a random one when none is live
    function bit [30:0] some_live_id();
      int s;
      if (live == 0) return 31'($urandom);
      do s = $urandom_range(NSLOT - 1); while (!sv[s]);
      return sid[s];
    endfunction
  endclass

  logic        clk, rst, cfg_we;
  logic [10:0] cfg_wdata;
  logic        s_axis_tvalid, s_axis_tready, s_axis_tuser;
  logic [47:0] s_axis_tdata;
  logic        m_axis_tvalid, m_axis_tready, m_axis_tuser;
  logic [31:0] m_axis_tdata;

  alloc_scoreboard sb;
  int send_idle_pct, recv_stall_pct;
  int wdog;
  bit done;

  buddy_block_allocator uut (
    .clk, .rst, .cfg_we, .cfg_wdata,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Receiver: random stall, check each response beat
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready)
        sb.check_response(m_axis_tuser, m_axis_tdata[30:0]);
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog on cycles without any beat
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      wdog <= 0;
    else if (!done) begin
      wdog <= wdog + 1;
      if (wdog >= WDOG_LIMIT) begin
        $display("FAIL buddy_block_allocator");
        $finish;
      end
    end
  end

  // Drive one request beat; valid stays up until the next idle or drain
  task automatic send_req(logic op, logic [15:0] size, logic [30:0] id);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {1'b0, id, size};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_request(op, size, id);
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  // Idle before a pool write, then reinit the model
  task automatic set_pool(logic [10:0] pool);
    drain();
    repeat (40) @(posedge clk);
    cfg_we <= 1; cfg_wdata <= pool;
    @(posedge clk);
    cfg_we <= 0;
    sb.init_pool(pool);
  endtask

  task automatic random_mix(int n);
    int k;
    logic [15:0] sz;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (k < 50) begin
        // mostly sizes that fit the pool, a few out of range
        case ($urandom_range(9))
          0:       sz = 16'($urandom);
          1:       sz = 0;
          default: sz = 16'($urandom_range((1 << sb.top) > 1 ? (1 << sb.top) / 2 : 1));
        endcase
        send_req(OP_ALLOC, sz, 31'($urandom));
      end else if (k < 90) begin
        send_req(OP_FREE, 16'($urandom), sb.some_live_id());
      end else begin
        send_req(OP_FREE, 16'($urandom), 31'($urandom));
      end
    end
  endtask

  initial begin
    int pools[6] = '{1024, 64, 1, 0, 2047, 300};
    sb = new();
    sb.init_pool(1024);
    send_idle_pct = 0; recv_stall_pct = 0; done = 0;
    cfg_we = 0; cfg_wdata = 0;
    s_axis_tvalid = 0; s_axis_tdata = 0; s_axis_tuser = 0;
    rst = 1;
    repeat (4) @(posedge clk);
    rst <= 0;

    // Directed: field extremes, zero size, too large, split and merge
    send_req(OP_ALLOC, 16'd0, 31'h7fffffff);
    send_req(OP_ALLOC, 16'hffff, 31'd0);
    send_req(OP_ALLOC, 16'd1025, '0);
    send_req(OP_ALLOC, 16'd1, '0);
    send_req(OP_ALLOC, 16'd3, '0);
    send_req(OP_ALLOC, 16'd1024, '0);
    send_req(OP_FREE, 16'hffff, 31'd1);
    send_req(OP_FREE, '0, 31'd2);
    send_req(OP_FREE, '0, 31'd2);
    send_req(OP_FREE, '0, 31'h7fffffff);
    send_req(OP_ALLOC, 16'd1024, '0);
    send_req(OP_ALLOC, 16'd1, '0);
    // one-byte pool, then fill the table
    set_pool(11'd1);
    send_req(OP_ALLOC, 16'd1, '0);
    send_req(OP_ALLOC, 16'd1, '0);
    send_req(OP_ALLOC, 16'd2, '0);
    set_pool(11'd1024);
    for (int i = 0; i < 66; i++) send_req(OP_ALLOC, 16'd1, '0);

    // Random phases per pool size and idle pattern
    for (int p = 0; p < 6; p++) begin
      set_pool(11'(pools[p]));
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
        default: begin send_idle_pct = 14; recv_stall_pct = 14; end
      endcase
      random_mix(45);
      drain();
      random_mix(45);
    end

    drain();
    done = 1;
    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("PASS buddy_block_allocator");
    else
      $display("FAIL buddy_block_allocator");
    $finish;
  end
endmodule

[buddy_block_allocator.f]
rtl/bba_pkg.sv
rtl/buddy_block_allocator.sv
sim/tb_buddy_block_allocator.sv
